FILE: design/cbt_pkg.sv
`timescale 1ns / 1ps

package cbt_pkg;

  // Field widths
  localparam int CLK_W   = 32;
  localparam int RATE_W  = 20;
  localparam int WORD_W  = 23;
  localparam int PRESC_W = 10;
  localparam int SEG1_W  = 4;
  localparam int SEG2_W  = 3;

  // Quanta search: counts MAX_QUANTA, MAX_QUANTA-2, ... down to the smallest usable (4)
  localparam int MAX_QUANTA = 24;
  localparam int MIN_QUANTA = 4;
  localparam int NT_W       = 5;
  localparam int NUM_LANES  = (MAX_QUANTA - MIN_QUANTA) / 2 + 1;

  // Divider bit counter
  localparam int CNT_W = $clog2(CLK_W);

  localparam logic [PRESC_W-1:0] PRESC_MAX = {PRESC_W{1'b1}};
  localparam logic [SEG1_W-1:0]  SEG1_MAX  = {SEG1_W{1'b1}};
  localparam logic [SEG2_W-1:0]  SEG2_MAX  = {SEG2_W{1'b1}};
  localparam logic [1:0]         SJW_CODE  = 2'd3;
  localparam int                 SJW_POS   = 14;
  localparam int                 SEG1_POS  = 16;
  localparam int                 SEG2_POS  = 20;

  typedef struct packed {
    logic [CLK_W-1:0]  peripheral_clock;
    logic [RATE_W-1:0] bit_rate;
  } cbt_in_t;

  typedef struct packed {
    logic [WORD_W-1:0]  btr_word;
    logic [PRESC_W-1:0] prescaler;
    logic [SEG1_W-1:0]  segment_one;
    logic [SEG2_W-1:0]  segment_two;
    logic               found;
    logic               prescaler_overflow;
  } cbt_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV1,
    ST_PICK,
    ST_DIV2,
    ST_DONE
  } cbt_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;       // capture operands, start budget division
    logic div_step;   // one restoring division step
    logic lane_step;  // feed new quotient bit into the divisibility lanes
    logic pick;       // choose quanta count, start prescaler division
    logic finish;     // register the result beat
  } cbt_cmd_t;

  // Quanta count handled by lane k
  function automatic logic [NT_W-1:0] lane_nt(input int k);
    lane_nt = NT_W'(MAX_QUANTA - 2 * k);
  endfunction

  // floor(n/3) for n below 32 via multiply by 11/32
  function automatic logic [NT_W-1:0] third_of(input logic [NT_W-1:0] n);
    logic [NT_W+3:0] prod;
    prod     = {4'd0, n} * (NT_W + 4)'(11);
    third_of = {1'b0, prod[NT_W+3:5]};
  endfunction

  // Segment one code: n - n/3 - 1 with n = nt - 1, saturated
  function automatic logic [SEG1_W-1:0] seg_one(input logic [NT_W-1:0] nt);
    logic [NT_W-1:0] n;
    logic [NT_W-1:0] s;
    n = nt - NT_W'(1);
    s = n - third_of(n) - NT_W'(1);
    seg_one = (s > NT_W'(SEG1_MAX)) ? SEG1_MAX : s[SEG1_W-1:0];
  endfunction

  // Segment two code: n/3 - 1 with n = nt - 1, saturated
  function automatic logic [SEG2_W-1:0] seg_two(input logic [NT_W-1:0] nt);
    logic [NT_W-1:0] n;
    logic [NT_W-1:0] s;
    n = nt - NT_W'(1);
    s = third_of(n) - NT_W'(1);
    seg_two = (s > NT_W'(SEG2_MAX)) ? SEG2_MAX : s[SEG2_W-1:0];
  endfunction

endpackage

FILE: design/cbt_ctrl.sv
`timescale 1ns / 1ps

module cbt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output cbt_pkg::cbt_cmd_t cmd
);

  cbt_pkg::cbt_state_t          state_r, state_nxt;
  logic [cbt_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;

  // State and bit counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cbt_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    busy      = 1'b1;
    unique case (state_r)
      cbt_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = cbt_pkg::ST_DIV1;
        end
      end
      cbt_pkg::ST_DIV1: begin
        cmd.div_step  = 1'b1;
        cmd.lane_step = 1'b1;
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == cbt_pkg::CNT_W'(cbt_pkg::CLK_W - 1)) begin
          state_nxt = cbt_pkg::ST_PICK;
        end
      end
      cbt_pkg::ST_PICK: begin
        cmd.pick  = 1'b1;
        cnt_nxt   = '0;
        state_nxt = cbt_pkg::ST_DIV2;
      end
      cbt_pkg::ST_DIV2: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == cbt_pkg::CNT_W'(cbt_pkg::CLK_W - 1)) begin
          state_nxt = cbt_pkg::ST_DONE;
        end
      end
      cbt_pkg::ST_DONE: begin
        cmd.finish = 1'b1;
        state_nxt  = cbt_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = cbt_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: design/cbt_datapath.sv
`timescale 1ns / 1ps

module cbt_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  cbt_pkg::cbt_cmd_t cmd,
  input  cbt_pkg::cbt_in_t  in_data,
  output logic              out_valid,
  output cbt_pkg::cbt_out_t out_data
);

  localparam int RW = cbt_pkg::RATE_W + 1;

  // Divider registers: dividend shifts out MSB first, quotient shifts in LSB
  logic [cbt_pkg::CLK_W-1:0]  dvd_r;
  logic [RW-1:0]              rem_r;
  logic [cbt_pkg::RATE_W-1:0] dvs_r;
  logic                       rate_zero_r;
  logic                       budget_nz_r;
  logic [cbt_pkg::NT_W-1:0]   lane_rem_r [cbt_pkg::NUM_LANES];
  logic [cbt_pkg::NT_W-1:0]   hit_r;
  logic                       found_r;
  logic                       out_valid_r;
  cbt_pkg::cbt_out_t          out_r;

  logic [RW-1:0]              rem_sh;
  logic                       qbit;
  logic [RW-1:0]              rem_step;
  logic [cbt_pkg::NT_W-1:0]   hit_sel;
  logic                       any_hit;
  logic [cbt_pkg::CLK_W-1:0]  q_m1;
  logic                       ovf;
  logic [cbt_pkg::PRESC_W-1:0] presc;
  logic [cbt_pkg::SEG1_W-1:0] s1;
  logic [cbt_pkg::SEG2_W-1:0] s2;
  cbt_pkg::cbt_out_t          res;

  // Restoring division step
  always_comb begin
    rem_sh   = {rem_r[RW-2:0], dvd_r[cbt_pkg::CLK_W-1]};
    qbit     = (rem_sh >= {1'b0, dvs_r});
    rem_step = qbit ? (rem_sh - {1'b0, dvs_r}) : rem_sh;
  end

  // First zero remainder from the largest quanta count down
  always_comb begin
    hit_sel = '0;
    any_hit = 1'b0;
    for (int k = cbt_pkg::NUM_LANES - 1; k >= 0; k--) begin
      if (lane_rem_r[k] == '0) begin
        hit_sel = cbt_pkg::lane_nt(k);
        any_hit = 1'b1;
      end
    end
  end

  // Result formation from prescaler quotient and chosen count
  always_comb begin
    q_m1  = dvd_r - cbt_pkg::CLK_W'(1);
    ovf   = (q_m1 > cbt_pkg::CLK_W'(cbt_pkg::PRESC_MAX));
    presc = ovf ? cbt_pkg::PRESC_MAX : q_m1[cbt_pkg::PRESC_W-1:0];
    s1    = cbt_pkg::seg_one(hit_r);
    s2    = cbt_pkg::seg_two(hit_r);
    res   = '0;
    if (found_r) begin
      res.prescaler          = presc;
      res.segment_one        = s1;
      res.segment_two        = s2;
      res.found              = 1'b1;
      res.prescaler_overflow = ovf;
      res.btr_word           = (cbt_pkg::WORD_W'(s2) << cbt_pkg::SEG2_POS)
                             | (cbt_pkg::WORD_W'(s1) << cbt_pkg::SEG1_POS)
                             | (cbt_pkg::WORD_W'(cbt_pkg::SJW_CODE) << cbt_pkg::SJW_POS)
                             | cbt_pkg::WORD_W'(presc);
    end
  end

  // Divider, lanes and selection
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dvd_r       <= in_data.peripheral_clock;
      dvs_r       <= in_data.bit_rate;
      rem_r       <= '0;
      rate_zero_r <= (in_data.bit_rate == '0);
      budget_nz_r <= 1'b0;
      for (int k = 0; k < cbt_pkg::NUM_LANES; k++) begin
        lane_rem_r[k] <= '0;
      end
    end else if (cmd.pick) begin
      // budget stays in dvd_r as the new dividend
      rem_r   <= '0;
      dvs_r   <= cbt_pkg::RATE_W'(hit_sel);
      hit_r   <= hit_sel;
      found_r <= any_hit && budget_nz_r && !rate_zero_r;
    end else if (cmd.div_step) begin
      dvd_r <= {dvd_r[cbt_pkg::CLK_W-2:0], qbit};
      rem_r <= rem_step;
      if (cmd.lane_step) begin
        budget_nz_r <= budget_nz_r | qbit;
        // budget mod nt, one quotient bit a cycle
        for (int k = 0; k < cbt_pkg::NUM_LANES; k++) begin
          if ({lane_rem_r[k], qbit} >= {1'b0, cbt_pkg::lane_nt(k)}) begin
            lane_rem_r[k] <= cbt_pkg::NT_W'({lane_rem_r[k], qbit}
                                            - {1'b0, cbt_pkg::lane_nt(k)});
          end else begin
            lane_rem_r[k] <= cbt_pkg::NT_W'({lane_rem_r[k], qbit});
          end
        end
      end
    end
  end

  // Result beat register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

FILE: design/can_bit_timing_calc_core.sv
`timescale 1ns / 1ps

// CAN bit timing calculator. Pulse start while busy is low with the peripheral
// clock and bitrate on in_data; busy then stays high while a bit-serial divider
// forms clock / bitrate (while eleven mod-nt lanes test every even quanta count
// from 24 down to 4 on the same quotient bits), the count is chosen, the
// divider forms the prescaler and the result is registered. The result beat is
// on out_data for exactly one cycle with out_valid high, the first cycle in
// which busy is low again; the receiver cannot stall it, so it must be captured
// in that cycle.

module can_bit_timing_calc_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  cbt_pkg::cbt_in_t  in_data,
  output logic              out_valid,
  output cbt_pkg::cbt_out_t out_data
);

  cbt_pkg::cbt_cmd_t cmd;

  // Sequencer
  cbt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  // Divider, divisibility lanes and result register
  cbt_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

FILE: test/tb_can_bit_timing_calc_core.sv
`timescale 1ns / 1ps

module tb_can_bit_timing_calc_core;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned RAND_ITEMS  = 950;
  localparam int unsigned TAIL_CYCLES = 100;
  // items in this window are sent back to back
  localparam int unsigned QUIET_FROM  = 300;
  localparam int unsigned QUIET_TO    = 550;

  logic              clk   = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  cbt_pkg::cbt_in_t  in_data = '0;
  logic              out_valid;
  cbt_pkg::cbt_out_t out_data;

  cbt_pkg::cbt_in_t  request_q[$];
  cbt_pkg::cbt_out_t timing_due[$];
  logic              in_taken = 1'b0;
  int unsigned       sent_count = 0;
  int unsigned       gap_left = 0;
  int unsigned       mismatch_count = 0;
  int unsigned       cycle_count = 0;

  int unsigned std_rates[9] = '{10000, 20000, 50000, 100000, 125000,
                                250000, 500000, 800000, 1000000};
  int unsigned odd_primes[14] = '{13, 17, 19, 23, 29, 31, 37, 41, 43, 47, 53, 59, 61, 67};

  can_bit_timing_calc_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  always #10 clk = ~clk;

  // Expected timing word for one clock / bitrate pair
  function automatic cbt_pkg::cbt_out_t calc_timing(input cbt_pkg::cbt_in_t req);
    cbt_pkg::cbt_out_t r;
    logic [31:0]       budget;
    int unsigned       nt;
    int unsigned       hit;
    int unsigned       n;
    int unsigned       third;
    int unsigned       presc;
    int unsigned       s1;
    int unsigned       s2;
    r   = '0;
    hit = 0;
    if (req.bit_rate != '0) begin
      budget = req.peripheral_clock / 32'(req.bit_rate);
      // first even quanta count, largest first, that divides the budget
      if (budget != 0) begin
        for (nt = cbt_pkg::MAX_QUANTA; nt >= 2 && hit == 0; nt -= 2) begin
          if (budget % nt == 0) hit = nt;
        end
      end
      // a count of 2 leaves no room for segment two: treated as not found
      if (hit >= 4) begin
        n     = hit - 1;
        third = n / 3;
        presc = budget / hit - 1;
        s1    = n - third - 1;
        s2    = third - 1;
        if (presc > cbt_pkg::PRESC_MAX) begin
          presc                = cbt_pkg::PRESC_MAX;
          r.prescaler_overflow = 1'b1;
        end
        if (s1 > cbt_pkg::SEG1_MAX) s1 = cbt_pkg::SEG1_MAX;
        if (s2 > cbt_pkg::SEG2_MAX) s2 = cbt_pkg::SEG2_MAX;
        r.prescaler   = presc[cbt_pkg::PRESC_W-1:0];
        r.segment_one = s1[cbt_pkg::SEG1_W-1:0];
        r.segment_two = s2[cbt_pkg::SEG2_W-1:0];
        r.found       = 1'b1;
        r.btr_word    = {r.segment_two, r.segment_one, cbt_pkg::SJW_CODE, 4'd0,
                         r.prescaler};
      end
    end
    return r;
  endfunction

  task automatic queue_req(input longint unsigned pclk, input int unsigned rate);
    cbt_pkg::cbt_in_t req;
    req.peripheral_clock = pclk[cbt_pkg::CLK_W-1:0];
    req.bit_rate         = rate[cbt_pkg::RATE_W-1:0];
    request_q.push_back(req);
  endtask

  task automatic report_field(input string fname, input longint unsigned want,
                              input longint unsigned got);
    $display("%0t: %s expected 0x%0h, got 0x%0h", $time, fname, want, got);
    mismatch_count++;
  endtask

  // Driver: presents the oldest pending request and holds it until taken
  always @(negedge clk) begin : drive
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !in_taken) begin
      // still waiting for the block to go idle
    end else begin
      if (start && in_taken) begin
        void'(request_q.pop_front());
        sent_count++;
        if ((sent_count < QUIET_FROM || sent_count > QUIET_TO) && $urandom_range(0, 99) < 10)
          gap_left = $urandom_range(1, 90);
      end
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (request_q.size() > 0) begin
        start   <= 1'b1;
        in_data <= request_q[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: checks result beats first, then records a newly accepted request
  always @(posedge clk) begin : observe
    cbt_pkg::cbt_out_t want;
    if (rst_n && out_valid) begin
      if (timing_due.size() == 0) begin
        $display("%0t: unexpected result beat 0x%0h", $time, out_data);
        mismatch_count++;
      end else begin
        want = timing_due.pop_front();
        if (out_data.btr_word != want.btr_word)
          report_field("btr_word", want.btr_word, out_data.btr_word);
        if (out_data.prescaler != want.prescaler)
          report_field("prescaler", want.prescaler, out_data.prescaler);
        if (out_data.segment_one != want.segment_one)
          report_field("segment_one", want.segment_one, out_data.segment_one);
        if (out_data.segment_two != want.segment_two)
          report_field("segment_two", want.segment_two, out_data.segment_two);
        if (out_data.found != want.found)
          report_field("found", want.found, out_data.found);
        if (out_data.prescaler_overflow != want.prescaler_overflow)
          report_field("prescaler_overflow", want.prescaler_overflow,
                       out_data.prescaler_overflow);
      end
    end
    if (rst_n && start && !busy) timing_due.push_back(calc_timing(in_data));
    in_taken <= rst_n && start && !busy;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned      sel;
    int unsigned      nt;
    int unsigned      rate;
    int unsigned      cap;
    int unsigned      p_max;
    int unsigned      presc;
    int unsigned      rem;
    longint unsigned  pclk;
    int unsigned      i;

    // Directed: every quanta count as the largest dividing count, with a remainder
    for (nt = cbt_pkg::MIN_QUANTA; nt <= cbt_pkg::MAX_QUANTA; nt += 2)
      queue_req(nt * 3 + 2, 3);
    queue_req(48_000_000, 0);              // zero bitrate
    queue_req(0, 500_000);                 // zero clock
    queue_req(999, 1000);                  // clock below bitrate
    queue_req(48_000_000, 500_000);        // typical setting
    queue_req(32'hFFFF_FFFF, 1);           // odd budget, nothing divides
    queue_req(32'hFFFF_FFF0, 1);           // huge prescaler, saturates
    queue_req(26, 1);                      // only a count of two divides
    queue_req(24 * 1024, 1);               // largest prescaler without saturation
    queue_req(24 * 1025, 1);               // just over the prescaler range
    queue_req(32'hFFFF_FFFF, 20'hFFFFF);   // both fields at their top
    queue_req(0, 20'hFFFFF);

    // Random: mostly exact divisors, then noise and broken requests
    for (i = 0; i < RAND_ITEMS; i++) begin
      sel = $urandom_range(0, 9);
      if (sel < 4) rate = std_rates[$urandom_range(0, 8)];
      else if (sel < 8) rate = $urandom_range(1, 1_000_000);
      else rate = $urandom_range(1, 20'hFFFFF);
      sel   = $urandom_range(0, 99);
      nt    = 2 * $urandom_range(2, 12);
      p_max = 32'hFFFF_FFFF / rate / nt;
      if (sel < 70 && p_max > 0) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: cap = 64;
          6, 7:             cap = 1100;
          default:          cap = p_max;
        endcase
        if (cap > p_max) cap = p_max;
        presc = $urandom_range(1, cap);
        pclk  = longint'(nt) * presc * rate;
        rem   = $urandom_range(0, rate - 1);
        if (pclk + rem > 64'hFFFF_FFFF) rem = 0;
        queue_req(pclk + rem, rate);
      end else if (sel < 85 || p_max == 0) begin
        queue_req($urandom, $urandom_range(0, 20'hFFFFF));
      end else begin
        rate = $urandom_range(1, 1_000_000);
        case ($urandom_range(0, 3))
          0: queue_req($urandom, 0);
          1: queue_req($urandom_range(0, rate - 1), rate);
          2: queue_req(longint'(2 * $urandom_range(0, 2000) + 1) * rate
                       + $urandom_range(0, rate - 1), rate);
          default: queue_req(longint'(2 * odd_primes[$urandom_range(0, 13)]) * rate
                             + $urandom_range(0, rate - 1), rate);
        endcase
      end
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (request_q.size() != 0 || start || timing_due.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/cbt_pkg.sv
design/cbt_ctrl.sv
design/cbt_datapath.sv
design/can_bit_timing_calc_core.sv
test/tb_can_bit_timing_calc_core.sv
